// File: sv/dab_pkg.sv
`default_nettype none
package dab_pkg;

  localparam int STACK_DEPTH = 16;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  localparam int CAP_W    = 19;
  localparam int SIZE_W   = 20;
  localparam int RSIZE_W  = SIZE_W + 1;
  localparam int SUM_W    = RSIZE_W + 1;
  localparam int OFFSET_W = 18;
  localparam int ACT_W    = 3;
  localparam int STAT_W   = 2;

  localparam logic [CAP_W-1:0] FRAME_CAP_RST   = 19'd16384;
  localparam logic [CAP_W-1:0] PERSIST_CAP_RST = 19'd65536;

  localparam logic [ACT_W-1:0] ACT_FRAME_ALLOC   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_FRAME_RESET   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_PERSIST_ALLOC = 3'd2;
  localparam logic [ACT_W-1:0] ACT_PUSH_MARK     = 3'd3;
  localparam logic [ACT_W-1:0] ACT_POP_MARK      = 3'd4;

  localparam logic [STAT_W-1:0] STAT_DONE      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_REFUSED   = 2'd1;
  localparam logic [STAT_W-1:0] STAT_PUSH_FULL = 2'd2;
  localparam logic [STAT_W-1:0] STAT_POP_EMPTY = 2'd3;

  localparam logic CFG_FRAME_CAP   = 1'b0;
  localparam logic CFG_PERSIST_CAP = 1'b1;

  typedef struct packed {
    logic load_in;
    logic commit;
  } dab_cmd_t;

endpackage
`default_nettype wire

// File: sv/dab_ctrl.sv
`default_nettype none
module dab_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_tvalid,
  output logic                   s_tready,
  output logic                   m_tvalid,
  input  wire logic              m_tready,
  output dab_pkg::dab_cmd_t      cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid;
  logic out_valid_next;
  logic commit;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;

  // result register frees up in the same cycle it is taken
  assign commit = (state == ST_EXEC) && (!out_valid || m_tready);

  assign cmd.load_in = s_tvalid && s_tready;
  assign cmd.commit  = commit;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (commit) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (commit) out_valid_next = 1'b1;
    else if (m_tready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_commit_only_exec: assert property (@(posedge clk) disable iff (rst)
    commit |-> $past(state_next) == ST_EXEC || $past(rst))
    else $error("commit outside execute state");

  a_commit_sets_valid: assert property (@(posedge clk) disable iff (rst)
    commit |=> out_valid)
    else $error("result lost after commit");

  a_no_accept_in_exec: assert property (@(posedge clk) disable iff (rst)
    cmd.load_in |=> state == ST_EXEC && !s_tready)
    else $error("second item taken during execute");

endmodule
`default_nettype wire

// File: sv/dab_dpath.sv
`default_nettype none
module dab_dpath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire dab_pkg::dab_cmd_t             cmd,
  input  wire logic [dab_pkg::ACT_W-1:0]     in_action,
  input  wire logic [dab_pkg::SIZE_W-1:0]    in_size,
  input  wire logic                          cfg_we,
  input  wire logic                          cfg_index,
  input  wire logic [dab_pkg::CAP_W-1:0]     cfg_data,
  output logic [dab_pkg::STAT_W-1:0]         status,
  output logic [dab_pkg::OFFSET_W-1:0]       offset,
  output logic [dab_pkg::CAP_W-1:0]          persist_used,
  output logic [dab_pkg::CAP_W-1:0]          persist_remaining
);

  logic [dab_pkg::ACT_W-1:0]   action;
  logic [dab_pkg::SIZE_W-1:0]  size;
  logic [dab_pkg::CAP_W-1:0]   frame_capacity;
  logic [dab_pkg::CAP_W-1:0]   persist_capacity;
  logic [dab_pkg::CAP_W-1:0]   frame_used;
  logic [dab_pkg::CAP_W-1:0]   persist_used_count;
  logic [dab_pkg::SP_W-1:0]    stack_pointer;
  logic [dab_pkg::CAP_W-1:0]   marks [dab_pkg::STACK_DEPTH];

  logic [dab_pkg::CAP_W-1:0]   frame_used_next;
  logic [dab_pkg::CAP_W-1:0]   persist_used_count_next;
  logic [dab_pkg::SP_W-1:0]    stack_pointer_next;
  logic [dab_pkg::SP_W-1:0]    sp_dec;
  logic                        mark_we;
  logic [dab_pkg::RSIZE_W-1:0] rounded;
  logic [dab_pkg::CAP_W-1:0]   alloc_used;
  logic [dab_pkg::CAP_W-1:0]   alloc_cap;
  logic [dab_pkg::SUM_W-1:0]   alloc_sum;
  logic                        alloc_fit;
  logic [dab_pkg::STAT_W-1:0]  status_next;
  logic [dab_pkg::OFFSET_W-1:0] offset_next;
  logic [dab_pkg::CAP_W-1:0]   remaining_next;
  logic                        stack_full;

  assign rounded = ({1'b0, size} + dab_pkg::RSIZE_W'(3)) & ~dab_pkg::RSIZE_W'(3);
  assign alloc_used = (action == dab_pkg::ACT_PERSIST_ALLOC) ? persist_used_count : frame_used;
  assign alloc_cap  = (action == dab_pkg::ACT_PERSIST_ALLOC) ? persist_capacity : frame_capacity;
  assign alloc_sum  = {3'b000, alloc_used} + {1'b0, rounded};
  assign alloc_fit  = alloc_sum <= {3'b000, alloc_cap};
  assign stack_full = stack_pointer >= dab_pkg::SP_W'(dab_pkg::STACK_DEPTH);
  assign sp_dec     = stack_pointer - dab_pkg::SP_W'(1);

  always_comb begin
    frame_used_next         = frame_used;
    persist_used_count_next = persist_used_count;
    stack_pointer_next      = stack_pointer;
    mark_we                 = 1'b0;
    status_next             = dab_pkg::STAT_DONE;
    offset_next             = '0;
    case (action)
      dab_pkg::ACT_FRAME_ALLOC, dab_pkg::ACT_PERSIST_ALLOC: begin
        if (alloc_fit) begin
          offset_next = alloc_used[dab_pkg::OFFSET_W-1:0];
          if (action == dab_pkg::ACT_PERSIST_ALLOC)
            persist_used_count_next = alloc_sum[dab_pkg::CAP_W-1:0];
          else
            frame_used_next = alloc_sum[dab_pkg::CAP_W-1:0];
        end else begin
          status_next = dab_pkg::STAT_REFUSED;
        end
      end
      dab_pkg::ACT_FRAME_RESET: begin
        frame_used_next = '0;
      end
      dab_pkg::ACT_PUSH_MARK: begin
        if (!stack_full) begin
          mark_we            = 1'b1;
          stack_pointer_next = stack_pointer + dab_pkg::SP_W'(1);
        end else begin
          status_next = dab_pkg::STAT_PUSH_FULL;
        end
      end
      dab_pkg::ACT_POP_MARK: begin
        if (stack_pointer != '0) begin
          stack_pointer_next      = sp_dec;
          persist_used_count_next = marks[sp_dec[dab_pkg::IDX_W-1:0]];
        end else begin
          status_next = dab_pkg::STAT_POP_EMPTY;
        end
      end
      default: ;
    endcase
  end

  // remaining saturates when capacity is lowered below what is in use
  assign remaining_next = (persist_capacity > persist_used_count_next)
                          ? persist_capacity - persist_used_count_next : '0;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      action <= in_action;
      size   <= in_size;
    end
    if (cmd.commit) begin
      status            <= status_next;
      offset            <= offset_next;
      persist_used      <= persist_used_count_next;
      persist_remaining <= remaining_next;
      if (mark_we) marks[stack_pointer[dab_pkg::IDX_W-1:0]] <= persist_used_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_capacity     <= dab_pkg::FRAME_CAP_RST;
      persist_capacity   <= dab_pkg::PERSIST_CAP_RST;
      frame_used         <= '0;
      persist_used_count <= '0;
      stack_pointer      <= '0;
    end else begin
      if (cfg_we && cfg_index == dab_pkg::CFG_FRAME_CAP) frame_capacity <= cfg_data;
      if (cfg_we && cfg_index == dab_pkg::CFG_PERSIST_CAP) persist_capacity <= cfg_data;
      if (cmd.commit) begin
        frame_used         <= frame_used_next;
        persist_used_count <= persist_used_count_next;
        stack_pointer      <= stack_pointer_next;
      end
    end
  end

  a_sp_bound: assert property (@(posedge clk) disable iff (rst)
    stack_pointer <= dab_pkg::SP_W'(dab_pkg::STACK_DEPTH))
    else $error("mark stack pointer past depth");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    !cmd.commit |=> $stable(frame_used) && $stable(persist_used_count)
                    && $stable(stack_pointer))
    else $error("arena state changed without a request");

  a_refuse_holds: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && status_next == dab_pkg::STAT_REFUSED
    |=> $stable(frame_used) && $stable(persist_used_count))
    else $error("refused allocation changed an arena");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    cmd.commit && action == dab_pkg::ACT_PUSH_MARK && !stack_full
    |=> stack_pointer == $past(stack_pointer) + dab_pkg::SP_W'(1))
    else $error("push did not advance the mark stack");

endmodule
`default_nettype wire

// File: sv/dual_arena_bump_allocator.sv
// Dual-arena bump allocator with a mark stack on the persistent arena.
// Input channel s_*: one request item per handshake, tdata = {size, action}.
// Output channel m_*: exactly one result item per request, tdata =
// {remaining, persist_used, offset, status}, zero padded to 64 bits.
// Config port: cfg_we writes cfg_data to register cfg_index
// (0 frame capacity, 1 persistent capacity); write only while idle.
// Timing: a request is captured in idle and enters execute in the next cycle,
// and the result appears on m_tvalid in the cycle after execute. No new request
// is taken until the last one has executed, since s_tready is high only in idle;
// a capture/execute controller runs around the combinational bump datapath
// (round, add, compare, mark stack access, remaining subtract).
// The next request may be taken while a result waits on m_*; if the receiver
// stalls, that next request is held in execute until the result register
// is taken, then commits in the same cycle.
// Reset (rst, synchronous): both arenas empty, mark stack empty, capacities
// back to 16384 and 65536 bytes, no result pending.
`default_nettype none
module dual_arena_bump_allocator (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // action[2:0], size[22:3], zero[23]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,   // status[1:0], offset[19:2],
                                      // persist_used[38:20],
                                      // persist_remaining[57:39], zero[63:58]
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [18:0] cfg_data
);

  dab_pkg::dab_cmd_t                   cmd;
  logic [dab_pkg::STAT_W-1:0]          status;
  logic [dab_pkg::OFFSET_W-1:0]        offset;
  logic [dab_pkg::CAP_W-1:0]           persist_used;
  logic [dab_pkg::CAP_W-1:0]           persist_remaining;

  dab_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  dab_dpath u_dpath (
    .clk               (clk),
    .rst               (rst),
    .cmd               (cmd),
    .in_action         (s_tdata[2:0]),
    .in_size           (s_tdata[22:3]),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .status            (status),
    .offset            (offset),
    .persist_used      (persist_used),
    .persist_remaining (persist_remaining)
  );

  assign m_tdata = {6'b000000, persist_remaining, persist_used, offset, status};

endmodule
`default_nettype wire

// File: sim/dual_arena_bump_allocator_tb.sv
`timescale 1ns / 100ps
module dual_arena_bump_allocator_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS = 275;

  typedef struct packed {
    logic [dab_pkg::STAT_W-1:0]   status;
    logic [dab_pkg::OFFSET_W-1:0] offset;
    logic [dab_pkg::CAP_W-1:0]    used;
    logic [dab_pkg::CAP_W-1:0]    remaining;
  } alloc_reply_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // action[2:0], size[22:3], zero[23]
  logic        m_tvalid;
  logic        m_tready;
  logic [63:0] m_tdata;   // status[1:0], offset[19:2], persist_used[38:20],
                          // persist_remaining[57:39], zero[63:58]
  logic        cfg_we;
  logic        cfg_index;
  logic [18:0] cfg_data;

  // allocator state as the bench sees it
  logic [dab_pkg::CAP_W-1:0] frame_cap_q;
  logic [dab_pkg::CAP_W-1:0] persist_cap_q;
  logic [dab_pkg::CAP_W-1:0] frame_used_q;
  logic [dab_pkg::CAP_W-1:0] persist_used_q;
  logic [dab_pkg::SP_W-1:0]  mark_depth_q;
  logic [dab_pkg::CAP_W-1:0] mark_stack_q [dab_pkg::STACK_DEPTH];

  alloc_reply_t predicted_replies[$];
  int           mismatch_count = 0;
  int           requests_sent;
  int           cycle_count = 0;
  logic         no_idle;

  dual_arena_bump_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) begin
    m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= 27);
  end

  // Granted when used + rounded size stays within capacity; offset is the
  // old used count, cut to the offset width.
  function automatic logic bump_arena(inout logic [dab_pkg::CAP_W-1:0] used,
                                      input logic [dab_pkg::CAP_W-1:0] cap,
                                      input logic [dab_pkg::SIZE_W-1:0] sz,
                                      output logic [dab_pkg::OFFSET_W-1:0] offs);
    logic [dab_pkg::RSIZE_W-1:0] rounded;
    logic [dab_pkg::SUM_W-1:0]   total;
    rounded = ({1'b0, sz} + dab_pkg::RSIZE_W'(3)) & ~dab_pkg::RSIZE_W'(3);
    total = dab_pkg::SUM_W'(used) + dab_pkg::SUM_W'(rounded);
    offs = '0;
    if (total > dab_pkg::SUM_W'(cap)) return 1'b0;
    offs = used[dab_pkg::OFFSET_W-1:0];
    used = total[dab_pkg::CAP_W-1:0];
    return 1'b1;
  endfunction

  function automatic alloc_reply_t model_request(logic [dab_pkg::ACT_W-1:0] act,
                                                 logic [dab_pkg::SIZE_W-1:0] sz);
    alloc_reply_t r;
    r = '0;
    r.status = dab_pkg::STAT_DONE;
    case (act)
      dab_pkg::ACT_FRAME_ALLOC: begin
        if (!bump_arena(frame_used_q, frame_cap_q, sz, r.offset))
          r.status = dab_pkg::STAT_REFUSED;
      end
      dab_pkg::ACT_FRAME_RESET: begin
        frame_used_q = '0;
      end
      dab_pkg::ACT_PERSIST_ALLOC: begin
        if (!bump_arena(persist_used_q, persist_cap_q, sz, r.offset))
          r.status = dab_pkg::STAT_REFUSED;
      end
      dab_pkg::ACT_PUSH_MARK: begin
        if (mark_depth_q < dab_pkg::SP_W'(dab_pkg::STACK_DEPTH)) begin
          mark_stack_q[mark_depth_q[dab_pkg::IDX_W-1:0]] = persist_used_q;
          mark_depth_q = mark_depth_q + 1'b1;
        end else begin
          r.status = dab_pkg::STAT_PUSH_FULL;
        end
      end
      dab_pkg::ACT_POP_MARK: begin
        if (mark_depth_q != '0) begin
          mark_depth_q = mark_depth_q - 1'b1;
          persist_used_q = mark_stack_q[mark_depth_q[dab_pkg::IDX_W-1:0]];
        end else begin
          r.status = dab_pkg::STAT_POP_EMPTY;
        end
      end
      default: ;
    endcase
    r.used = persist_used_q;
    r.remaining = (persist_cap_q > persist_used_q) ? persist_cap_q - persist_used_q : '0;
    return r;
  endfunction

  always @(posedge clk) begin : reply_check
    alloc_reply_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (predicted_replies.size() == 0) begin
        $error("unexpected reply item %h", m_tdata);
        mismatch_count++;
      end else begin
        want = predicted_replies.pop_front();
        if (m_tdata[1:0] !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_tdata[1:0]);
          mismatch_count++;
        end
        if (m_tdata[19:2] !== want.offset) begin
          $error("offset: expected %0d, got %0d", want.offset, m_tdata[19:2]);
          mismatch_count++;
        end
        if (m_tdata[38:20] !== want.used) begin
          $error("persist_used: expected %0d, got %0d", want.used, m_tdata[38:20]);
          mismatch_count++;
        end
        if (m_tdata[57:39] !== want.remaining) begin
          $error("persist_remaining: expected %0d, got %0d", want.remaining,
                 m_tdata[57:39]);
          mismatch_count++;
        end
      end
    end
  end

  // Called and returns just after a falling edge; tvalid is left high so
  // back-to-back items need no second assignment in one step.
  task automatic send_request(input logic [dab_pkg::ACT_W-1:0] act,
                              input logic [dab_pkg::SIZE_W-1:0] sz);
    while (!no_idle && $urandom_range(99) < 27) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, sz, act};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted_replies.push_back(model_request(act, sz));
    requests_sent++;
    @(negedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (predicted_replies.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_capacity(input logic idx, input logic [dab_pkg::CAP_W-1:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == dab_pkg::CFG_FRAME_CAP) frame_cap_q = val;
    else persist_cap_q = val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [dab_pkg::SIZE_W-1:0] pick_size(
      logic [dab_pkg::CAP_W-1:0] cap, logic [dab_pkg::CAP_W-1:0] used);
    logic [dab_pkg::CAP_W-1:0] gap;
    gap = (cap > used) ? cap - used : '0;
    case ($urandom_range(9))
      0: return dab_pkg::SIZE_W'($urandom());
      1: return '0;
      2: return dab_pkg::SIZE_W'(gap) + dab_pkg::SIZE_W'($urandom_range(4));
      3, 4, 5: return dab_pkg::SIZE_W'($urandom_range(int'(cap >> 4) + 3));
      default: return dab_pkg::SIZE_W'($urandom_range(255));
    endcase
  endfunction

  task automatic send_random_item();
    int pick;
    pick = $urandom_range(99);
    if (pick < 30)
      send_request(dab_pkg::ACT_FRAME_ALLOC, pick_size(frame_cap_q, frame_used_q));
    else if (pick < 36)
      send_request(dab_pkg::ACT_FRAME_RESET, dab_pkg::SIZE_W'($urandom()));
    else if (pick < 66)
      send_request(dab_pkg::ACT_PERSIST_ALLOC, pick_size(persist_cap_q, persist_used_q));
    else if (pick < 80)
      send_request(dab_pkg::ACT_PUSH_MARK, dab_pkg::SIZE_W'($urandom()));
    else if (pick < 94)
      send_request(dab_pkg::ACT_POP_MARK, dab_pkg::SIZE_W'($urandom()));
    else
      send_request(dab_pkg::ACT_POP_MARK + dab_pkg::ACT_W'($urandom_range(1, 3)),
                   dab_pkg::SIZE_W'($urandom()));
  endtask

  // long run of pushes or pops with persistent allocations between them,
  // which can walk the mark stack to full or empty and past it
  task automatic send_mark_run(input logic [dab_pkg::ACT_W-1:0] act);
    int n;
    n = $urandom_range(12, 20);
    repeat (n) begin
      send_request(act, dab_pkg::SIZE_W'($urandom()));
      if ($urandom_range(1))
        send_request(dab_pkg::ACT_PERSIST_ALLOC, pick_size(persist_cap_q, persist_used_q));
    end
  endtask

  task automatic test_basic_requests();
    send_request(dab_pkg::ACT_FRAME_ALLOC, '0);
    send_request(dab_pkg::ACT_FRAME_ALLOC, dab_pkg::SIZE_W'(1));
    send_request(dab_pkg::ACT_FRAME_ALLOC, dab_pkg::SIZE_W'(5));
    send_request(dab_pkg::ACT_FRAME_ALLOC, '1);
    // exact fill
    send_request(dab_pkg::ACT_FRAME_ALLOC, dab_pkg::SIZE_W'(frame_cap_q - frame_used_q));
    send_request(dab_pkg::ACT_FRAME_ALLOC, '0);  // zero size on a full arena
    send_request(dab_pkg::ACT_FRAME_RESET, '1);
    send_request(dab_pkg::ACT_PERSIST_ALLOC, dab_pkg::SIZE_W'(100));
    send_request(dab_pkg::ACT_PUSH_MARK, '0);
    send_request(dab_pkg::ACT_PERSIST_ALLOC, dab_pkg::SIZE_W'(3));
    send_request(dab_pkg::ACT_POP_MARK, '0);
    send_request(dab_pkg::ACT_POP_MARK, '1);  // empty stack
    send_request(dab_pkg::ACT_POP_MARK + dab_pkg::ACT_W'(1), '1);
    send_request(dab_pkg::ACT_POP_MARK + dab_pkg::ACT_W'(2), dab_pkg::SIZE_W'(7));
    send_request(dab_pkg::ACT_POP_MARK + dab_pkg::ACT_W'(3), '0);
  endtask

  task automatic test_capacity_extremes();
    write_capacity(dab_pkg::CFG_FRAME_CAP, '0);
    write_capacity(dab_pkg::CFG_PERSIST_CAP, dab_pkg::CAP_W'(262144));
    send_request(dab_pkg::ACT_FRAME_ALLOC, '0);
    send_request(dab_pkg::ACT_FRAME_ALLOC, dab_pkg::SIZE_W'(1));
    send_request(dab_pkg::ACT_PERSIST_ALLOC, '1);
    send_request(dab_pkg::ACT_PERSIST_ALLOC,
                 dab_pkg::SIZE_W'(persist_cap_q - persist_used_q));
    send_request(dab_pkg::ACT_PERSIST_ALLOC, '0);  // offset wraps past 18 bits
    send_request(dab_pkg::ACT_PUSH_MARK, '0);
    // capacity dropped under the used count
    write_capacity(dab_pkg::CFG_PERSIST_CAP, dab_pkg::CAP_W'(4));
    send_request(dab_pkg::ACT_PERSIST_ALLOC, '0);
    send_request(dab_pkg::ACT_POP_MARK, '0);
    send_request(dab_pkg::ACT_FRAME_RESET, '0);
  endtask

  task automatic test_random_traffic();
    logic [dab_pkg::CAP_W-1:0] frame_caps [6];
    logic [dab_pkg::CAP_W-1:0] persist_caps [6];
    int stop_at;
    int pick;
    frame_caps = '{dab_pkg::CAP_W'(4096), dab_pkg::CAP_W'(262144), dab_pkg::CAP_W'(0),
                   dab_pkg::CAP_W'($urandom_range(262144)), dab_pkg::CAP_W'(256),
                   dab_pkg::FRAME_CAP_RST};
    persist_caps = '{dab_pkg::CAP_W'(16384), dab_pkg::CAP_W'(262144), dab_pkg::CAP_W'(0),
                     dab_pkg::CAP_W'($urandom_range(262144)), dab_pkg::CAP_W'(1024),
                     dab_pkg::PERSIST_CAP_RST};
    for (int p = 0; p < 6; p++) begin
      write_capacity(dab_pkg::CFG_FRAME_CAP, frame_caps[p]);
      write_capacity(dab_pkg::CFG_PERSIST_CAP, persist_caps[p]);
      no_idle = (p == 1);
      stop_at = requests_sent + PHASE_ITEMS;
      while (requests_sent < stop_at) begin
        pick = $urandom_range(99);
        if (pick < 6) send_mark_run(dab_pkg::ACT_PUSH_MARK);
        else if (pick < 12) send_mark_run(dab_pkg::ACT_POP_MARK);
        else send_random_item();
      end
      no_idle = 1'b0;
    end
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = dab_pkg::CFG_FRAME_CAP;
    cfg_data = '0;
    no_idle = 1'b0;
    requests_sent = 0;
    frame_cap_q = dab_pkg::FRAME_CAP_RST;
    persist_cap_q = dab_pkg::PERSIST_CAP_RST;
    frame_used_q = '0;
    persist_used_q = '0;
    mark_depth_q = '0;
    foreach (mark_stack_q[i]) mark_stack_q[i] = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_basic_requests();
    test_capacity_extremes();
    test_random_traffic();
    wait_idle();

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/dab_pkg.sv
sv/dab_ctrl.sv
sv/dab_dpath.sv
sv/dual_arena_bump_allocator.sv
sim/dual_arena_bump_allocator_tb.sv
